/* rtl/tenm_pkg.sv */
// Shared types, codes and defaults of the tagged entry nearest match block.
package tenm_pkg;

    localparam int ENTRIES_DEF = 1024;
    localparam int TAGS_DEF = 4;
    localparam int GROUPS_DEF = 64;
    localparam logic [31:0] BEST_INIT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_GROUP   = 2'd1,
        MODE_NEAREST = 2'd2,
        MODE_FIRST   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [9:0]         entry_index;
        logic [1:0]         tag_slot;
        logic [2:0]         tag_total;
        logic [7:0]         tag_kind;
        logic signed [31:0] tag_value;
        logic [5:0]         group_id;
        logic [9:0]         group_start;
        logic [10:0]        group_size;
    } t_in_word;

    typedef struct packed {
        logic [9:0] chosen_entry;
        logic       found;
    } t_out_word;

    typedef struct packed {
        logic [7:0]         kind;
        logic signed [31:0] value;
    } t_tag;

    typedef struct packed {
        logic [9:0]  start;
        logic [10:0] size;
    } t_grp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_GRP,
        ST_GLOAD,
        ST_ENTRY,
        ST_CNT,
        ST_SLOT,
        ST_TAG,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic cap;
        logic wr;
        logic walk_init;
        logic cnt_ld;
        logic slot_inc;
        logic ent_inc;
        logic diff_ld;
        logic cmp;
        logic hit_first;
    } t_cmd;

    typedef struct packed {
        logic  clr_last;
        logic  entry_ok;
        logic  slot_ok;
        logic  kind_hit;
        t_mode mode;
    } t_stat;

endpackage

/* rtl/tenm_dp.sv */
// Datapath: tag, count and group memories, walk counters and best-difference tracking.
module tenm_dp
    import tenm_pkg::*;
#(
    parameter int ENTRIES        = ENTRIES_DEF,
    parameter int TAGS_PER_ENTRY = TAGS_DEF,
    parameter int GROUPS         = GROUPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_word  i_in,
    output t_stat     o_stat,
    output t_out_word o_out
);

    localparam int SLOTS = ENTRIES * TAGS_PER_ENTRY;
    localparam int EW    = $clog2(ENTRIES);
    localparam int TW    = $clog2(SLOTS);
    localparam int TBW   = $clog2(SLOTS + 1);
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW    = $clog2(TAGS_PER_ENTRY + 1);
    localparam int CLRN  = (ENTRIES > GROUPS) ? ENTRIES : GROUPS;
    localparam int CLW   = $clog2(CLRN);

    logic [CW-1:0] cnt_mem [ENTRIES];
    t_grp          grp_mem [GROUPS];
    t_tag          tag_mem [SLOTS];

    t_in_word           r_req;
    logic [CLW-1:0]     r_clr;
    logic [11:0]        r_idx;
    logic [10:0]        r_off;
    logic [10:0]        r_size;
    logic [TBW-1:0]     r_base;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_slot;
    logic [31:0]        r_best;
    logic signed [32:0] r_diff;
    logic [9:0]         r_chosen;
    logic               r_found;
    logic [CW-1:0]      r_cnt_rd;
    t_grp               r_grp_rd;
    t_tag               r_tag_rd;

    logic           ld_entry_ok;
    logic           ld_slot_ok;
    logic           gid_ok;
    logic [CW-1:0]  ld_count;
    logic [TW-1:0]  ld_tag_addr;
    logic           cnt_we;
    logic [EW-1:0]  cnt_waddr;
    logic [CW-1:0]  cnt_wdata;
    logic           grp_we;
    logic [GW-1:0]  grp_waddr;
    t_grp           grp_wdata;
    logic [32:0]    abs_diff;
    logic           win;
    t_grp           walk_grp;

    // Decode of the captured request for loads and group writes.
    always_comb begin
        ld_entry_ok = 32'(r_req.entry_index) < 32'(ENTRIES);
        ld_slot_ok  = 32'(r_req.tag_slot) < 32'(TAGS_PER_ENTRY);
        gid_ok      = 32'(r_req.group_id) < 32'(GROUPS);
        ld_count    = (32'(r_req.tag_total) > 32'(TAGS_PER_ENTRY)) ?
                      CW'(TAGS_PER_ENTRY) : CW'(r_req.tag_total);
        ld_tag_addr = TW'(32'(EW'(r_req.entry_index)) * TAGS_PER_ENTRY
                          + 32'(r_req.tag_slot));
    end

    // Count and group write ports are shared by the clear sweep and the writes.
    always_comb begin
        if (i_cmd.clr_wr) begin
            cnt_we    = 32'(r_clr) < 32'(ENTRIES);
            cnt_waddr = EW'(r_clr);
            cnt_wdata = '0;
            grp_we    = 32'(r_clr) < 32'(GROUPS);
            grp_waddr = GW'(r_clr);
            grp_wdata = '0;
        end else begin
            cnt_we    = i_cmd.wr && (r_req.mode == MODE_LOAD) && ld_entry_ok;
            cnt_waddr = EW'(r_req.entry_index);
            cnt_wdata = ld_count;
            grp_we    = i_cmd.wr && (r_req.mode == MODE_GROUP) && gid_ok;
            grp_waddr = GW'(r_req.group_id);
            grp_wdata = '{start: r_req.group_start, size: r_req.group_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= cnt_mem[EW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (grp_we) begin
            grp_mem[grp_waddr] <= grp_wdata;
        end
        r_grp_rd <= grp_mem[GW'(r_req.group_id)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (r_req.mode == MODE_LOAD) && ld_entry_ok && ld_slot_ok) begin
            tag_mem[ld_tag_addr] <= '{kind: r_req.tag_kind, value: r_req.tag_value};
        end
        r_tag_rd <= tag_mem[TW'(r_base + TBW'(r_slot))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + CLW'(1);
        end
    end

    always_comb begin
        abs_diff = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
        win      = abs_diff < {1'b0, r_best};
        walk_grp = gid_ok ? r_grp_rd : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req    <= i_in;
            r_chosen <= '0;
            r_found  <= 1'b0;
        end
        if (i_cmd.walk_init) begin
            r_idx  <= 12'(walk_grp.start);
            r_off  <= '0;
            r_size <= walk_grp.size;
            r_base <= TBW'(32'(walk_grp.start) * TAGS_PER_ENTRY);
            r_best <= BEST_INIT;
            if (r_req.mode == MODE_NEAREST) begin
                r_chosen <= walk_grp.start;
            end
        end
        if (i_cmd.cnt_ld) begin
            r_cnt  <= r_cnt_rd;
            r_slot <= '0;
        end
        if (i_cmd.slot_inc) begin
            r_slot <= r_slot + CW'(1);
        end
        if (i_cmd.diff_ld) begin
            r_diff  <= $signed({r_tag_rd.value[31], r_tag_rd.value})
                       - $signed({r_req.tag_value[31], r_req.tag_value});
            r_found <= 1'b1;
        end
        if (i_cmd.hit_first) begin
            r_chosen <= r_idx[9:0];
            r_found  <= 1'b1;
        end
        if (i_cmd.cmp && win) begin
            r_best   <= abs_diff[31:0];
            r_chosen <= r_idx[9:0];
        end
        if (i_cmd.ent_inc || i_cmd.cmp) begin
            r_idx  <= r_idx + 12'd1;
            r_off  <= r_off + 11'd1;
            r_base <= r_base + TBW'(TAGS_PER_ENTRY);
        end
    end

    always_comb begin
        o_stat.clr_last = r_clr == CLW'(CLRN - 1);
        o_stat.entry_ok = (r_off < r_size) && (32'(r_idx) < 32'(ENTRIES));
        o_stat.slot_ok  = r_slot < r_cnt;
        o_stat.kind_hit = r_tag_rd.kind == r_req.tag_kind;
        o_stat.mode     = r_req.mode;
        o_out.chosen_entry = r_chosen;
        o_out.found        = r_found;
    end

endmodule

/* rtl/tenm_ctrl.sv */
// Controller: state machine that sequences clearing, writes and the query walk.
module tenm_ctrl
    import tenm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // The captured mode decides whether this was a write or a query.
                unique case (i_stat.mode)
                    MODE_LOAD, MODE_GROUP:     n_state = ST_DONE;
                    MODE_NEAREST, MODE_FIRST:  n_state = ST_GRP;
                endcase
            end
            ST_GRP:   n_state = ST_GLOAD;
            ST_GLOAD: n_state = ST_ENTRY;
            ST_ENTRY: n_state = i_stat.entry_ok ? ST_CNT : ST_DONE;
            ST_CNT:   n_state = ST_SLOT;
            ST_SLOT:  n_state = i_stat.slot_ok ? ST_TAG : ST_ENTRY;
            ST_TAG: begin
                priority if (!i_stat.kind_hit) begin
                    n_state = ST_SLOT;
                end else if (i_stat.mode == MODE_FIRST) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:   n_state = ST_ENTRY;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                o_busy    = 1'b0;
                o_cmd.cap = i_start;
            end
            ST_WRITE: o_cmd.wr = 1'b1;
            ST_GRP: begin
            end
            ST_GLOAD: o_cmd.walk_init = 1'b1;
            ST_ENTRY: begin
            end
            ST_CNT:   o_cmd.cnt_ld = 1'b1;
            ST_SLOT:  o_cmd.ent_inc = !i_stat.slot_ok;
            ST_TAG: begin
                priority if (!i_stat.kind_hit) begin
                    o_cmd.slot_inc = 1'b1;
                end else if (i_stat.mode == MODE_FIRST) begin
                    o_cmd.hit_first = 1'b1;
                end else begin
                    o_cmd.diff_ld = 1'b1;
                end
            end
            ST_CMP:   o_cmd.cmp = 1'b1;
            ST_DONE:  o_valid = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

/* rtl/tagged_entry_nearest_match.sv */
// Top level of the tagged entry nearest match block: controller plus datapath.
// A load or group word passes through the write and done states after acceptance and is strobed
// in done. A query reads its group, sets up the walk, then reads each entry's tag count and its
// slots in turn; a first query stops at its first matching tag. Each word ends before the next.
// Reset: synchronous; afterwards the block is busy while it
// clears the tag counts and group table. Results are strobed for one cycle; no stall exists.
module tagged_entry_nearest_match
    import tenm_pkg::*;
#(
    parameter int ENTRIES        = ENTRIES_DEF,
    parameter int TAGS_PER_ENTRY = TAGS_DEF,
    parameter int GROUPS         = GROUPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_result_valid,
    output t_out_word o_out
);

    // The controller and datapath talk only through these two structs.
    t_cmd  cmd;
    t_stat stat;

    // The controller owns the sequencing: clear sweep after reset, then one word at a
    // time. It raises busy in every state except idle, so start is taken only when the
    // previous word's result has already been strobed out.
    tenm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_valid (o_result_valid),
        .o_cmd   (cmd)
    );

    // The datapath holds the tag memory, the per-entry tag counts and the group table,
    // each with a registered read port, plus the walk counters and best-difference
    // register. The difference is taken in 33 bits and its magnitude compared in the cycle after.
    tenm_dp #(
        .ENTRIES        (ENTRIES),
        .TAGS_PER_ENTRY (TAGS_PER_ENTRY),
        .GROUPS         (GROUPS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_stat  (stat),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    // A result is only strobed while a word is in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    // An accepted word always occupies the block in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // Each word yields exactly one strobe, never two back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");
`endif

endmodule
